>>> sv/mrg5_pkg.sv
// ----------------------------------------------------------------------------
// mrg5_pkg
// Types and constants of the order-5 recursive generator modulo 2^31-1,
// plus the Mersenne folding reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package mrg5_pkg;

  localparam int unsigned NSTAGES = 5;

  localparam logic [30:0] MOD_P    = 31'h7FFF_FFFF;
  localparam logic [26:0] MUL_NEW  = 27'd107374182;
  localparam logic [26:0] MUL_OLD  = 27'd104480;
  localparam logic [26:0] LCG_MUL  = 27'd69069;

  // stage words after a reseed from one
  localparam logic [30:0] RST_S0 = 31'd1;
  localparam logic [30:0] RST_S1 = 31'd69070;
  localparam logic [30:0] RST_S2 = 31'd475628535;
  localparam logic [30:0] RST_S3 = 31'd1129920461;
  localparam logic [30:0] RST_S4 = 31'd772999773;

  localparam logic [1:0] REQ_DRAW   = 2'd0;
  localparam logic [1:0] REQ_RESEED = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_M1,
    ST_DRAW_M2,
    ST_DRAW_ADD,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_LOAD,
    ST_FINISH
  } state_t;

  // full reduction mod 2^31-1 of a value below 2^59
  function automatic logic [30:0] mod_p_fold(input logic [58:0] v);
    logic [31:0] t;
    logic [30:0] u;
    t = {1'b0, v[30:0]} + {4'd0, v[58:31]};
    u = t[30:0] + {30'd0, t[31]};
    return (u == MOD_P) ? 31'd0 : u;
  endfunction

endpackage

`default_nettype wire

>>> sv/mrg5_uniform_generator.sv
// ----------------------------------------------------------------------------
// mrg5_uniform_generator
// Order-5 multiple recursive generator modulo 2^31-1 with reseed and
// single-stage load requests.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A draw forms two products on
// the shared 32x27 multiplier, then one modular add and a result step; a
// reseed passes each of the five stages through the multiplier, with an
// increment between each pair of them; a load writes its stage and an unused
// request goes straight to the result step. The input stalls while a request
// is at work and is ready again on the cycle after the result is registered.
// The result sits in an output register so the next transaction can be
// accepted while it waits; a further result holds in its final step until
// that register is free. Reset leaves the stages as a reseed from one.
`default_nettype none

module mrg5_uniform_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_seed_value,
  input  wire logic [2:0]  in_stage_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_random_value
);

  mrg5_pkg::state_t state_r, state_nxt;

  logic [30:0] stage_r [mrg5_pkg::NSTAGES];
  logic [31:0] x_r;
  logic [2:0]  idx_r;
  logic [2:0]  k_r;
  logic [58:0] prod_r;
  logic [30:0] acc_r;
  logic        out_valid_r;
  logic [30:0] out_value_r;

  logic        in_take;
  logic        out_free;
  logic [31:0] mul_a;
  logic [26:0] mul_b;
  logic [58:0] mul_res;
  logic [30:0] red_prod;
  logic [31:0] sum;
  logic [30:0] fresh;
  logic [30:0] seed_mod;
  logic [30:0] load_word;

  assign in_stall = (state_r != mrg5_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      mrg5_pkg::ST_DRAW_M1: begin
        mul_a = {1'b0, stage_r[0]};
        mul_b = mrg5_pkg::MUL_NEW;
      end
      mrg5_pkg::ST_DRAW_M2: begin
        mul_a = {1'b0, stage_r[mrg5_pkg::NSTAGES-1]};
        mul_b = mrg5_pkg::MUL_OLD;
      end
      default: begin
        mul_a = x_r;
        mul_b = mrg5_pkg::LCG_MUL;
      end
    endcase
  end

  assign mul_res   = 59'(mul_a) * 59'(mul_b);
  assign red_prod  = mrg5_pkg::mod_p_fold(prod_r);
  assign sum       = {1'b0, acc_r} + {1'b0, red_prod};
  assign fresh     = (sum >= {1'b0, mrg5_pkg::MOD_P}) ? 31'(sum - {1'b0, mrg5_pkg::MOD_P})
                                                       : sum[30:0];
  assign seed_mod  = mrg5_pkg::mod_p_fold({27'd0, x_r});
  assign load_word = (seed_mod == 31'd0) ? 31'd1 : seed_mod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrg5_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrg5_pkg::ST_IDLE: begin
        if (in_take) begin
          case (in_req_type)
            mrg5_pkg::REQ_DRAW:   state_nxt = mrg5_pkg::ST_DRAW_M1;
            mrg5_pkg::REQ_RESEED: state_nxt = mrg5_pkg::ST_SEED_MUL;
            mrg5_pkg::REQ_LOAD:   state_nxt = mrg5_pkg::ST_LOAD;
            default:              state_nxt = mrg5_pkg::ST_FINISH;
          endcase
        end
      end
      mrg5_pkg::ST_DRAW_M1:  state_nxt = mrg5_pkg::ST_DRAW_M2;
      mrg5_pkg::ST_DRAW_M2:  state_nxt = mrg5_pkg::ST_DRAW_ADD;
      mrg5_pkg::ST_DRAW_ADD: state_nxt = mrg5_pkg::ST_FINISH;
      mrg5_pkg::ST_SEED_MUL: begin
        state_nxt = (k_r == 3'(mrg5_pkg::NSTAGES - 1)) ? mrg5_pkg::ST_FINISH
                                                       : mrg5_pkg::ST_SEED_ADD;
      end
      mrg5_pkg::ST_SEED_ADD: state_nxt = mrg5_pkg::ST_SEED_MUL;
      mrg5_pkg::ST_LOAD:     state_nxt = mrg5_pkg::ST_FINISH;
      mrg5_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = mrg5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mrg5_pkg::ST_IDLE;
    endcase
  end

  // stage words are architectural state, so they take the reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r[0] <= mrg5_pkg::RST_S0;
      stage_r[1] <= mrg5_pkg::RST_S1;
      stage_r[2] <= mrg5_pkg::RST_S2;
      stage_r[3] <= mrg5_pkg::RST_S3;
      stage_r[4] <= mrg5_pkg::RST_S4;
    end else begin
      case (state_r)
        mrg5_pkg::ST_DRAW_ADD: begin
          for (int i = mrg5_pkg::NSTAGES - 1; i > 0; i--) begin
            stage_r[i] <= stage_r[i-1];
          end
          stage_r[0] <= fresh;
        end
        mrg5_pkg::ST_SEED_MUL: begin
          stage_r[k_r] <= seed_mod;
        end
        mrg5_pkg::ST_LOAD: begin
          if (idx_r < 3'(mrg5_pkg::NSTAGES)) begin
            stage_r[idx_r] <= load_word;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd0;
    end else if (in_take) begin
      k_r <= 3'd0;
    end else if (state_r == mrg5_pkg::ST_SEED_ADD) begin
      k_r <= k_r + 3'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r   <= in_seed_value;
      idx_r <= in_stage_index;
    end else if (state_r == mrg5_pkg::ST_SEED_ADD) begin
      x_r <= prod_r[31:0] + 32'd1;
    end
    if (state_r == mrg5_pkg::ST_DRAW_M1 || state_r == mrg5_pkg::ST_DRAW_M2 ||
        state_r == mrg5_pkg::ST_SEED_MUL) begin
      prod_r <= mul_res;
    end
    if (state_r == mrg5_pkg::ST_DRAW_M2) begin
      acc_r <= red_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == mrg5_pkg::ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mrg5_pkg::ST_FINISH && out_free) begin
      out_value_r <= stage_r[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

`ifndef NO_ASSERTIONS
  // an accepted transaction keeps the input stalled on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after a transaction was taken");

  // results are fully reduced
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_random_value != mrg5_pkg::MOD_P))
    else $error("result equals the modulus");

  // reseed counter stays within the stages
  a_seed_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrg5_pkg::ST_SEED_MUL || state_r == mrg5_pkg::ST_SEED_ADD)
      |-> (k_r < 3'(mrg5_pkg::NSTAGES)))
    else $error("reseed stage index out of range");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_value_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> tb/mrg5_result_checker.sv
// ----------------------------------------------------------------------------
// mrg5_result_checker
// Watches both channels of the order-5 recursive generator, predicts each
// result from its own copy of the five stage words and compares in order.
// ----------------------------------------------------------------------------
module mrg5_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_seed_value,
  input  logic [2:0]  in_stage_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [30:0] out_random_value,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [30:0] stages [mrg5_pkg::NSTAGES];
  logic [30:0] expected_values [$];
  logic [30:0] want;
  int          failures;

  // applies one request to the predicted stages and returns the result word
  function automatic logic [30:0] next_value(input logic [1:0] req,
                                             input logic [31:0] seed,
                                             input logic [2:0] idx);
    logic [63:0] acc;
    logic [31:0] x;
    logic [30:0] w;
    int          k;
    case (req)
      mrg5_pkg::REQ_DRAW: begin
        acc = 64'(mrg5_pkg::MUL_NEW) * stages[0]
            + 64'(mrg5_pkg::MUL_OLD) * stages[mrg5_pkg::NSTAGES-1];
        w = 31'(acc % 64'(mrg5_pkg::MOD_P));
        for (k = mrg5_pkg::NSTAGES - 1; k > 0; k--) stages[k] = stages[k-1];
        stages[0] = w;
      end
      mrg5_pkg::REQ_RESEED: begin
        x = seed;
        for (k = 0; k < mrg5_pkg::NSTAGES; k++) begin
          stages[k] = 31'(x % {1'b0, mrg5_pkg::MOD_P});
          x = x * 32'(mrg5_pkg::LCG_MUL) + 32'd1;
        end
      end
      mrg5_pkg::REQ_LOAD: begin
        if (idx < mrg5_pkg::NSTAGES) begin
          w = 31'(seed % {1'b0, mrg5_pkg::MOD_P});
          if (w == 31'd0) w = 31'd1;
          stages[idx] = w;
        end
      end
      default: ;
    endcase
    return stages[0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stages[0] = mrg5_pkg::RST_S0;
      stages[1] = mrg5_pkg::RST_S1;
      stages[2] = mrg5_pkg::RST_S2;
      stages[3] = mrg5_pkg::RST_S3;
      stages[4] = mrg5_pkg::RST_S4;
      expected_values.delete();
    end else begin
      // a result always belongs to an earlier transaction, so check before queueing
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          $error("random_value: unexpected result, actual %0d", out_random_value);
          failures++;
        end else begin
          want = expected_values.pop_front();
          if (want !== out_random_value) begin
            $error("random_value: expected %0d, actual %0d", want, out_random_value);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_values.push_back(next_value(in_req_type, in_seed_value, in_stage_index));
    end
    outstanding <= expected_values.size();
    fail_count  <= failures;
  end

endmodule

>>> tb/mrg5_uniform_generator_tb.sv
// ----------------------------------------------------------------------------
// mrg5_uniform_generator_tb
// Drives draws, reseeds, stage loads and unused requests into the generator
// under varying sender and receiver idling; the checker judges every result.
// ----------------------------------------------------------------------------
module mrg5_uniform_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 120;
  localparam int         IDLE_LIMIT  = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [31:0] in_seed_value;
  logic [2:0]  in_stage_index;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_random_value;
  int          fail_count;
  int          outstanding;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  mrg5_uniform_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_seed_value    (in_seed_value),
    .in_stage_index   (in_stage_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value)
  );

  mrg5_result_checker result_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_seed_value    (in_seed_value),
    .in_stage_index   (in_stage_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off whenever one is requested
  initial begin
    out_stall = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles in which neither channel moves a transaction
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [1:0] req, input logic [31:0] seed,
                           input logic [2:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_seed_value  <= seed;
    in_stage_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFE;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int count);
    int          sel;
    logic [2:0]  idx;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        send_item(mrg5_pkg::REQ_DRAW, $urandom, 3'($urandom_range(7)));
      end else if (sel < 74) begin
        send_item(mrg5_pkg::REQ_RESEED, pick_seed(), 3'($urandom_range(7)));
      end else if (sel < 94) begin
        // mostly real stages, now and then an index past the last one
        idx = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        send_item(mrg5_pkg::REQ_LOAD, pick_seed(), idx);
      end else begin
        send_item(REQ_UNUSED, $urandom, 3'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = mrg5_pkg::REQ_DRAW;
    in_seed_value  = 32'd0;
    in_stage_index = 3'd0;
    send_idle_pct  = 17;
    recv_stall_pct = 78;
    hold_requests  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // draws straight from the reset stages
    repeat (3) send_item(mrg5_pkg::REQ_DRAW, 32'd0, 3'd0);
    // every stage at p-1 gives the largest sum a draw can reduce
    for (int k = 0; k < 5; k++) send_item(mrg5_pkg::REQ_LOAD, 32'h7FFF_FFFE, 3'(k));
    send_item(mrg5_pkg::REQ_DRAW, 32'hFFFF_FFFF, 3'd7);
    // loads that reduce to zero are replaced by one, beside loads that reduce to one
    send_item(mrg5_pkg::REQ_LOAD, 32'h0000_0000, 3'd0);
    send_item(mrg5_pkg::REQ_LOAD, 32'h7FFF_FFFF, 3'd1);
    send_item(mrg5_pkg::REQ_LOAD, 32'hFFFF_FFFF, 3'd2);
    send_item(mrg5_pkg::REQ_LOAD, 32'h8000_0000, 3'd3);
    // loads past the last stage write nothing
    for (int k = 5; k < 8; k++) send_item(mrg5_pkg::REQ_LOAD, 32'h1234_5678, 3'(k));
    send_item(REQ_UNUSED, 32'hFFFF_FFFF, 3'd7);
    // reseeds, including ones that leave a zero stage
    send_item(mrg5_pkg::REQ_RESEED, 32'h0000_0000, 3'd0);
    send_item(mrg5_pkg::REQ_DRAW, 32'd0, 3'd0);
    send_item(mrg5_pkg::REQ_RESEED, 32'h7FFF_FFFF, 3'd0);
    send_item(mrg5_pkg::REQ_DRAW, 32'd0, 3'd0);
    send_item(mrg5_pkg::REQ_RESEED, 32'hFFFF_FFFF, 3'd0);
    send_item(mrg5_pkg::REQ_DRAW, 32'd0, 3'd0);
    send_item(mrg5_pkg::REQ_RESEED, 32'h0000_0001, 3'd0);
    send_item(mrg5_pkg::REQ_DRAW, 32'd0, 3'd0);
    drain();

    send_random(300);
    drain();

    send_idle_pct  = 78;
    recv_stall_pct = 17;
    send_random(300);
    drain();

    // no idling, with long receiver hold-offs while items keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    send_random(160);
    hold_requests <= hold_requests + 1;
    send_random(165);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
